FILE: rtl/ipaw_pkg.sv
// ----------------------------------------------------------------------------
// ipaw_pkg: shared definitions for the incremental pid angle wrap unit
// Field widths, angle and rounding constants, register indexes and register reset values.
// ----------------------------------------------------------------------------
package ipaw_pkg;

    // field widths
    localparam int ANGLE_W = 15;
    localparam int GAIN_W  = 20;
    localparam int DRIVE_W = 28;
    localparam int CFG_W   = 28;
    localparam int IDX_W   = 3;

    // derived arithmetic widths
    localparam int DIFF_W  = ANGLE_W + 2;
    localparam int COEF_W  = GAIN_W + 2;
    localparam int PROD_W  = COEF_W + ANGLE_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int FRAC_W  = 12;
    localparam int DELTA_W = ACC_W - FRAC_W;
    localparam int SUM_W   = DRIVE_W + 1;

    // angle constants in Q3.12
    localparam logic signed [DIFF_W-1:0] ANG_PI     = DIFF_W'(12868);
    localparam logic signed [DIFF_W-1:0] ANG_TWO_PI = DIFF_W'(25736);

    // half an lsb of Q12, for rounding the Q24 sum
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2048);

    // register indexes
    localparam logic [IDX_W-1:0] REG_PROP_GAIN  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_INT_GAIN_T = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_DER_GAIN_T = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_OUT_MAX    = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_OUT_MIN    = IDX_W'(4);

    // register reset values
    localparam logic [GAIN_W-1:0]         PROP_GAIN_RST = GAIN_W'(8192);
    localparam logic signed [DRIVE_W-1:0] OUT_MAX_RST   = DRIVE_W'(40960);
    localparam logic signed [DRIVE_W-1:0] OUT_MIN_RST   = -DRIVE_W'(40960);

endpackage

FILE: rtl/incremental_pid_angle_wrap_unit.sv
// ----------------------------------------------------------------------------
// incremental_pid_angle_wrap_unit: velocity-form pid for heading control
// Stages: input register, products, rounded delta, then the drive register.
// Throughput: one transaction per cycle unless m_ready stalls the output
// stage, set by the add and clamp loop through the previous drive register.
// Reset (aresetn low, synchronous): pipeline emptied, state and error history
// cleared to zero, gains and clamp limits back to their reset values.
// Wraps the angle error once into [-pi, pi], forms a0*e - a1*e1 + a2*e2 in
// Q24, rounds to Q12, adds it to the previous drive and clamps the result.
// ----------------------------------------------------------------------------
module incremental_pid_angle_wrap_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [ipaw_pkg::IDX_W-1:0]             cfg_index,
    input  logic [ipaw_pkg::CFG_W-1:0]             cfg_wdata,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [ipaw_pkg::ANGLE_W-1:0]    s_ref_angle,
    input  logic signed [ipaw_pkg::ANGLE_W-1:0]    s_feedback_angle,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [ipaw_pkg::DRIVE_W-1:0]    m_drive
);

    localparam int ANGLE_W = ipaw_pkg::ANGLE_W;
    localparam int GAIN_W  = ipaw_pkg::GAIN_W;
    localparam int DRIVE_W = ipaw_pkg::DRIVE_W;
    localparam int DIFF_W  = ipaw_pkg::DIFF_W;
    localparam int COEF_W  = ipaw_pkg::COEF_W;
    localparam int PROD_W  = ipaw_pkg::PROD_W;
    localparam int ACC_W   = ipaw_pkg::ACC_W;
    localparam int FRAC_W  = ipaw_pkg::FRAC_W;
    localparam int DELTA_W = ipaw_pkg::DELTA_W;
    localparam int SUM_W   = ipaw_pkg::SUM_W;

    // configuration registers
    logic [GAIN_W-1:0]         prop_gain_reg;
    logic [GAIN_W-1:0]         int_gain_reg;
    logic [GAIN_W-1:0]         der_gain_reg;
    logic signed [DRIVE_W-1:0] out_max_reg;
    logic signed [DRIVE_W-1:0] out_min_reg;

    // folded coefficients
    logic [COEF_W-1:0] a0_reg;
    logic [COEF_W-1:0] a1_reg;
    logic [COEF_W-1:0] a2_reg;

    // pipeline registers
    logic                       a_valid_reg;
    logic signed [ANGLE_W-1:0]  a_ref_reg;
    logic signed [ANGLE_W-1:0]  a_fb_reg;
    logic                       b_valid_reg;
    logic signed [PROD_W-1:0]   p0_reg;
    logic signed [PROD_W-1:0]   p1_reg;
    logic signed [PROD_W-1:0]   p2_reg;
    logic                       c_valid_reg;
    logic signed [DELTA_W-1:0]  delta_reg;
    logic                       m_valid_reg;
    logic signed [DRIVE_W-1:0]  drive_reg;

    // error history
    logic signed [ANGLE_W-1:0]  err_last_reg;
    logic signed [ANGLE_W-1:0]  err_prev_reg;

    // handshake
    logic out_ready;
    logic c_ready;
    logic b_ready;
    logic a_load;
    logic b_load;
    logic c_load;
    logic out_load;

    // datapath
    logic signed [DIFF_W-1:0]  diff;
    logic signed [DIFF_W-1:0]  diff_wrap;
    logic signed [ANGLE_W-1:0] err_next;
    logic signed [PROD_W-1:0]  prod0;
    logic signed [PROD_W-1:0]  prod1;
    logic signed [PROD_W-1:0]  prod2;
    logic signed [ACC_W-1:0]   acc;
    logic signed [DELTA_W-1:0] delta_next;
    logic signed [SUM_W-1:0]   sum_drive;
    logic signed [SUM_W-1:0]   max_ext;
    logic signed [SUM_W-1:0]   min_ext;
    logic signed [SUM_W-1:0]   upper_clamped;
    logic signed [DRIVE_W-1:0] drive_next;

    assign out_ready = !m_valid_reg || m_ready;
    assign c_ready   = !c_valid_reg || out_ready;
    assign b_ready   = !b_valid_reg || c_ready;
    assign s_ready   = !a_valid_reg || b_ready;

    assign a_load   = s_valid && s_ready;
    assign b_load   = a_valid_reg && b_ready;
    assign c_load   = b_valid_reg && c_ready;
    assign out_load = c_valid_reg && out_ready;

    assign m_valid = m_valid_reg;
    assign m_drive = drive_reg;

    // configuration writes, unknown indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg <= ipaw_pkg::PROP_GAIN_RST;
            int_gain_reg  <= '0;
            der_gain_reg  <= '0;
            out_max_reg   <= ipaw_pkg::OUT_MAX_RST;
            out_min_reg   <= ipaw_pkg::OUT_MIN_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                ipaw_pkg::REG_PROP_GAIN:  prop_gain_reg <= cfg_wdata[GAIN_W-1:0];
                ipaw_pkg::REG_INT_GAIN_T: int_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                ipaw_pkg::REG_DER_GAIN_T: der_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                ipaw_pkg::REG_OUT_MAX:    out_max_reg   <= cfg_wdata[DRIVE_W-1:0];
                ipaw_pkg::REG_OUT_MIN:    out_min_reg   <= cfg_wdata[DRIVE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // coefficients follow the gains in the cycle after a change
    always_ff @(posedge aclk) begin
        a0_reg <= COEF_W'(prop_gain_reg) + COEF_W'(int_gain_reg) + COEF_W'(der_gain_reg);
        a1_reg <= COEF_W'(prop_gain_reg) + (COEF_W'(der_gain_reg) << 1);
        a2_reg <= COEF_W'(der_gain_reg);
    end

    // single wrap of the angle error
    always_comb begin
        diff = DIFF_W'(a_ref_reg) - DIFF_W'(a_fb_reg);
        if (diff > ipaw_pkg::ANG_PI) begin
            diff_wrap = diff - ipaw_pkg::ANG_TWO_PI;
        end else if (diff < -ipaw_pkg::ANG_PI) begin
            diff_wrap = diff + ipaw_pkg::ANG_TWO_PI;
        end else begin
            diff_wrap = diff;
        end
        err_next = diff_wrap[ANGLE_W-1:0];
    end

    // three independent Q24 products, operands extended to the product width
    assign prod0 = $signed({{(PROD_W-COEF_W){1'b0}}, a0_reg})
                 * PROD_W'(err_next);
    assign prod1 = $signed({{(PROD_W-COEF_W){1'b0}}, a1_reg})
                 * PROD_W'(err_last_reg);
    assign prod2 = $signed({{(PROD_W-COEF_W){1'b0}}, a2_reg})
                 * PROD_W'(err_prev_reg);

    // round half up to Q12: add half an lsb, then arithmetic shift (floor)
    assign acc = ACC_W'(p0_reg) - ACC_W'(p1_reg) + ACC_W'(p2_reg) + ipaw_pkg::ROUND_HALF;
    assign delta_next = acc[ACC_W-1:FRAC_W];

    // accumulate and clamp, upper limit first so inverted limits give out_min
    // both compares run on the full-width sum so nothing wraps before clamping
    always_comb begin
        sum_drive = SUM_W'(drive_reg) + SUM_W'(delta_reg);
        max_ext   = SUM_W'(out_max_reg);
        min_ext   = SUM_W'(out_min_reg);
        if (sum_drive > max_ext) begin
            upper_clamped = max_ext;
        end else begin
            upper_clamped = sum_drive;
        end
        if (upper_clamped < min_ext) begin
            drive_next = out_min_reg;
        end else begin
            drive_next = upper_clamped[DRIVE_W-1:0];
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
            if (out_ready) begin
                m_valid_reg <= c_valid_reg;
            end
        end
    end

    // payload stages
    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_ref_reg <= s_ref_angle;
            a_fb_reg  <= s_feedback_angle;
        end
        if (b_load) begin
            p0_reg <= prod0;
            p1_reg <= prod1;
            p2_reg <= prod2;
        end
        if (c_load) begin
            delta_reg <= delta_next;
        end
    end

    // controller state: error history moves with the multiply stage,
    // the output register doubles as the previous drive
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_last_reg <= '0;
            err_prev_reg <= '0;
            drive_reg    <= '0;
        end else begin
            if (b_load) begin
                err_prev_reg <= err_last_reg;
                err_last_reg <= err_next;
            end
            if (out_load) begin
                drive_reg <= drive_next;
            end
        end
    end

    // stored error always lies within plus or minus pi
    assert property (@(posedge aclk) disable iff (!aresetn)
        (SUM_W'(err_last_reg) <= SUM_W'(ipaw_pkg::ANG_PI))
        && (SUM_W'(err_last_reg) >= -SUM_W'(ipaw_pkg::ANG_PI)))
        else $error("wrapped error outside plus or minus pi");

    // with ordered limits a new drive lies inside them
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && (out_min_reg <= out_max_reg)
        |=> (drive_reg <= $past(out_max_reg)) && (drive_reg >= $past(out_min_reg)))
        else $error("drive outside clamp limits");

    // a stalled delta stage keeps its transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && !out_ready |=> c_valid_reg && $stable(delta_reg))
        else $error("delta stage lost a stalled transaction");

    // the error history only moves when a transaction enters the multiply stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        !b_load |=> $stable(err_last_reg) && $stable(err_prev_reg))
        else $error("error history changed without a transaction");

endmodule
